### rtl/core/twio_pkg.sv
// twio_pkg: shared types, constants and the sine table generator for the
// tracking wheel odometry unit. No dependencies; used by twio_ctrl, twio_dp
// and the top level.
package twio_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegXScale = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegYScale = CfgIdxW'(1);

  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  localparam logic [63:0] Q31One    = 64'd2147483648;
  localparam logic [63:0] HalfPiQ31 = 64'd3373259426;

  // operand selection of the shared 32x32 multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DX,
    MUL_DY,
    MUL_LO,
    MUL_HI
  } mul_op_e;

  // per-cycle commands from the sequencer to the datapath
  typedef struct packed {
    logic    load;      // capture an accepted item
    mul_op_e mul_op;
    logic    d_y;       // displacement operand: 0 x wheel, 1 y wheel
    logic    s_sin;     // trig operand: 0 cosine, 1 sine
    logic    t_neg;     // term is subtracted
    logic    rom_rd;
    logic    rom_cos;   // table read for cosine angle
    logic    cos_ld;
    logic    sin_ld;
    logic    dx_ld;
    logic    dy_ld;
    logic    lo_ld;
    logic    tm_ld;
    logic    add_en;
    logic    add_y;
    logic    add_init;  // start from the stored accumulator
    logic    commit;
  } dp_cmd_t;

  // quarter-wave sine entry, unsigned Q1.31, truncated taylor series in horner form
  function automatic logic [31:0] sine_entry(input logic [63:0] k,
                                             input int unsigned abits);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] r;
    u  = (k * HalfPiQ31) >> abits;
    u2 = (u * u) >> 31;
    r  = Q31One;
    r  = Q31One - (((u2 * r) >> 31) / 64'd272);
    r  = Q31One - (((u2 * r) >> 31) / 64'd210);
    r  = Q31One - (((u2 * r) >> 31) / 64'd156);
    r  = Q31One - (((u2 * r) >> 31) / 64'd110);
    r  = Q31One - (((u2 * r) >> 31) / 64'd72);
    r  = Q31One - (((u2 * r) >> 31) / 64'd42);
    r  = Q31One - (((u2 * r) >> 31) / 64'd20);
    r  = Q31One - (((u2 * r) >> 31) / 64'd6);
    return 32'((u * r) >> 31);
  endfunction

endpackage

### rtl/core/tracking_wheel_imu_odometry_unit.sv
// tracking_wheel_imu_odometry_unit: dead-reckoning tracker top level.
// Depends on twio_pkg, twio_ctrl and twio_dp.
//
// Usage:
//  - input channel (in_valid_i / in_stall_o) carries one beat per item:
//    cmd_i 0 updates from wheel counts and imu yaw, cmd_i 1 forces x, y
//    and heading. Every item gives exactly one output beat.
//  - output channel (out_valid_o / out_stall_i) carries pos_x_o, pos_y_o
//    (Q16.16 m) and heading_o (binary angle). The result sits in the state
//    registers themselves and holds while the receiver stalls.
//  - config channel (cfg_valid_i / cfg_ready_o) writes the wheel scales;
//    ready is always high; the user must make writes go in while the unit
//    is idle, which the unit itself does not enforce.
//  - update items run ten products on one shared 32x32 multiplier and two
//    reads of the single sine rom port, then commit, then idle; set items
//    go straight to commit. Output valid rises with the committed result.
//  - a finished item waits in the commit state while an earlier output
//    beat is still stalled; input stays stalled meanwhile.
//  - reset clears position, heading, offset, previous counts and scales.
module tracking_wheel_imu_odometry_unit #(
  parameter int unsigned SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [twio_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic signed [31:0]            x_count_i,
  input  logic signed [31:0]            y_count_i,
  input  logic [31:0]                   imu_angle_i,
  input  logic signed [31:0]            new_x_i,
  input  logic signed [31:0]            new_y_i,
  input  logic [31:0]                   new_heading_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic [31:0]                   heading_o
);

  twio_pkg::dp_cmd_t ctl;
  logic              cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  twio_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  twio_dp #(
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .ctl_i         (ctl),
    .cmd_i         (cmd_i),
    .x_count_i     (x_count_i),
    .y_count_i     (y_count_i),
    .imu_angle_i   (imu_angle_i),
    .new_x_i       (new_x_i),
    .new_y_i       (new_y_i),
    .new_heading_i (new_heading_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .heading_o     (heading_o)
  );

endmodule

### rtl/core/twio_dp.sv
// twio_dp: odometry datapath with the shared multiplier, sine rom,
// term and accumulator registers, and the configuration registers.
// Depends on twio_pkg; driven by commands from twio_ctrl.
module twio_dp #(
  parameter int unsigned SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twio_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  twio_pkg::dp_cmd_t             ctl_i,
  input  logic                          cmd_i,
  input  logic signed [31:0]            x_count_i,
  input  logic signed [31:0]            y_count_i,
  input  logic [31:0]                   imu_angle_i,
  input  logic signed [31:0]            new_x_i,
  input  logic signed [31:0]            new_y_i,
  input  logic [31:0]                   new_heading_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic [31:0]                   heading_o
);

  localparam int unsigned AddrBits = SINE_TABLE_ADDR_BITS;
  localparam int unsigned RomAw    = AddrBits + 1;
  localparam int unsigned RomDepth = (1 << AddrBits) + 1;

  // configuration and persistent state
  logic [31:0] scale_x_q, scale_y_q;
  logic [47:0] x_acc_q, y_acc_q;
  logic [31:0] last_hd_q, hd_off_q;
  logic [31:0] prev_x_q, prev_y_q;

  // item and working registers
  logic        set_q;
  logic [31:0] xc_q, yc_q, hd_q, nx_q, ny_q, nh_q;
  logic [31:0] dltm_x_q, dltm_y_q;
  logic        dneg_x_q, dneg_y_q;
  logic [63:0] prod_q;
  logic [62:0] dmag_x_q, dmag_y_q;
  logic [31:0] rom_q, cmag_q, smag_q;
  logic        rom_neg_q, cneg_q, sneg_q;
  logic [32:0] lo_q;
  logic        psgn_q, tneg_q;
  logic [62:0] tmag_q;
  logic [65:0] sum_x_q, sum_y_q;

  logic [31:0]       dlt_x, dlt_y, dltm_x, dltm_y;
  logic [31:0]       rom_ang;
  logic [AddrBits-1:0] rom_idx;
  logic [RomAw-1:0]  rom_addr;
  logic [62:0]       dsel;
  logic [31:0]       ssel;
  logic [31:0]       opa, opb;
  logic [63:0]       prod;
  logic [63:0]       msum;
  logic [62:0]       tmag_d;
  logic              psgn_d;
  logic [65:0]       acc_ext, add_base, addend, add_res;

  // constant quarter-wave table, built at elaboration
  logic [31:0] sine_rom [RomDepth];
  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    localparam logic [31:0] Entry = twio_pkg::sine_entry(64'(k), AddrBits);
    assign sine_rom[k] = Entry;
  end

  function automatic logic [47:0] clamp_acc(input logic [65:0] s);
    logic [47:0] r;
    if (s[65:47] == '0 || s[65:47] == '1) begin
      r = s[47:0];
    end else if (s[65]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  // wheel count change, wrapped to 32 bits, as sign and magnitude
  assign dlt_x  = $unsigned(x_count_i) - prev_x_q;
  assign dlt_y  = $unsigned(y_count_i) - prev_y_q;
  assign dltm_x = dlt_x[31] ? (32'd0 - dlt_x) : dlt_x;
  assign dltm_y = dlt_y[31] ? (32'd0 - dlt_y) : dlt_y;

  // quadrant folding into the quarter-wave table
  assign rom_ang  = ctl_i.rom_cos ? (hd_q + twio_pkg::QuarterTurn) : hd_q;
  assign rom_idx  = rom_ang[29 -: AddrBits];
  assign rom_addr = rom_ang[30] ? (RomAw'(RomDepth - 1) - {1'b0, rom_idx})
                                : {1'b0, rom_idx};

  assign dsel = ctl_i.d_y ? dmag_y_q : dmag_x_q;
  assign ssel = ctl_i.s_sin ? smag_q : cmag_q;

  always_comb begin
    opa = '0;
    opb = '0;
    case (ctl_i.mul_op)
      twio_pkg::MUL_DX: begin
        opa = dltm_x_q;
        opb = scale_x_q;
      end
      twio_pkg::MUL_DY: begin
        opa = dltm_y_q;
        opb = scale_y_q;
      end
      twio_pkg::MUL_LO: begin
        opa = dsel[31:0];
        opb = ssel;
      end
      twio_pkg::MUL_HI: begin
        opa = {1'b0, dsel[62:32]};
        opb = ssel;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = {32'd0, opa} * {32'd0, opb};

  // (hi << 1) + (lo >> 31), modulo 2^64, then limited to 63 bits
  assign msum   = {prod_q[62:0], 1'b0} + {31'd0, lo_q};
  assign tmag_d = msum[63] ? {63{1'b1}} : msum[62:0];
  assign psgn_d = (ctl_i.d_y ? dneg_y_q : dneg_x_q) ^ (ctl_i.s_sin ? sneg_q : cneg_q)
                  ^ ctl_i.t_neg;

  assign acc_ext  = ctl_i.add_y ? {{18{y_acc_q[47]}}, y_acc_q}
                                : {{18{x_acc_q[47]}}, x_acc_q};
  assign add_base = ctl_i.add_init ? acc_ext : (ctl_i.add_y ? sum_y_q : sum_x_q);
  assign addend   = {3'b000, tmag_q};
  assign add_res  = tneg_q ? (add_base - addend) : (add_base + addend);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      set_q    <= cmd_i;
      xc_q     <= $unsigned(x_count_i);
      yc_q     <= $unsigned(y_count_i);
      hd_q     <= imu_angle_i + hd_off_q;
      nx_q     <= $unsigned(new_x_i);
      ny_q     <= $unsigned(new_y_i);
      nh_q     <= new_heading_i;
      dltm_x_q <= dltm_x;
      dltm_y_q <= dltm_y;
      dneg_x_q <= dlt_x[31];
      dneg_y_q <= dlt_y[31];
    end
    if (ctl_i.mul_op != twio_pkg::MUL_NONE) begin
      prod_q <= prod;
    end
    if (ctl_i.mul_op == twio_pkg::MUL_HI) begin
      psgn_q <= psgn_d;
    end
    if (ctl_i.dx_ld) begin
      dmag_x_q <= prod_q[62:0];
    end
    if (ctl_i.dy_ld) begin
      dmag_y_q <= prod_q[62:0];
    end
    if (ctl_i.rom_rd) begin
      rom_q     <= sine_rom[rom_addr];
      rom_neg_q <= rom_ang[31];
    end
    if (ctl_i.cos_ld) begin
      cmag_q <= rom_q;
      cneg_q <= rom_neg_q;
    end
    if (ctl_i.sin_ld) begin
      smag_q <= rom_q;
      sneg_q <= rom_neg_q;
    end
    if (ctl_i.lo_ld) begin
      lo_q <= prod_q[63:31];
    end
    if (ctl_i.tm_ld) begin
      tmag_q <= tmag_d;
      tneg_q <= psgn_q;
    end
    if (ctl_i.add_en) begin
      if (ctl_i.add_y) begin
        sum_y_q <= add_res;
      end else begin
        sum_x_q <= add_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= '0;
      scale_y_q <= '0;
      x_acc_q   <= '0;
      y_acc_q   <= '0;
      last_hd_q <= '0;
      hd_off_q  <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == twio_pkg::RegXScale) begin
        scale_x_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == twio_pkg::RegYScale) begin
        scale_y_q <= cfg_data_i;
      end
      if (ctl_i.commit) begin
        if (set_q) begin
          x_acc_q   <= {nx_q, 16'd0};
          y_acc_q   <= {ny_q, 16'd0};
          hd_off_q  <= nh_q - last_hd_q;
          last_hd_q <= nh_q;
        end else begin
          x_acc_q   <= clamp_acc(sum_x_q);
          y_acc_q   <= clamp_acc(sum_y_q);
          last_hd_q <= hd_q;
          prev_x_q  <= xc_q;
          prev_y_q  <= yc_q;
        end
      end
    end
  end

  assign pos_x_o   = $signed(x_acc_q[47:16]);
  assign pos_y_o   = $signed(y_acc_q[47:16]);
  assign heading_o = last_hd_q;

endmodule

### rtl/core/twio_ctrl.sv
// twio_ctrl: sequencer for the odometry datapath; walks the multiplier
// and sine rom schedule and owns the input stall and output valid.
// Depends on twio_pkg for the command struct.
module twio_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output twio_pkg::dp_cmd_t ctl_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_LO_A,
    ST_HI_A,
    ST_LO_B,
    ST_HI_B,
    ST_LO_C,
    ST_HI_C,
    ST_LO_D,
    ST_HI_D,
    ST_TERM_D,
    ST_ADD_D,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // a taken beat clears valid, a commit raises it again
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == ST_COMMIT && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= in_cmd_i ? ST_COMMIT : ST_MUL_DX;
          end
        end
        ST_MUL_DX: state_q <= ST_MUL_DY;
        ST_MUL_DY: state_q <= ST_LO_A;
        ST_LO_A:   state_q <= ST_HI_A;
        ST_HI_A:   state_q <= ST_LO_B;
        ST_LO_B:   state_q <= ST_HI_B;
        ST_HI_B:   state_q <= ST_LO_C;
        ST_LO_C:   state_q <= ST_HI_C;
        ST_HI_C:   state_q <= ST_LO_D;
        ST_LO_D:   state_q <= ST_HI_D;
        ST_HI_D:   state_q <= ST_TERM_D;
        ST_TERM_D: state_q <= ST_ADD_D;
        ST_ADD_D:  state_q <= ST_COMMIT;
        ST_COMMIT: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // schedule: term a = dx*cos, b = -dy*sin (x); c = dx*sin, d = dy*cos (y)
  always_comb begin
    ctl_o        = '0;
    ctl_o.mul_op = twio_pkg::MUL_NONE;
    case (state_q)
      ST_IDLE: ctl_o.load = in_valid_i;
      ST_MUL_DX: begin
        ctl_o.mul_op  = twio_pkg::MUL_DX;
        ctl_o.rom_rd  = 1'b1;
        ctl_o.rom_cos = 1'b1;
      end
      ST_MUL_DY: begin
        ctl_o.mul_op = twio_pkg::MUL_DY;
        ctl_o.dx_ld  = 1'b1;
        ctl_o.rom_rd = 1'b1;
        ctl_o.cos_ld = 1'b1;
      end
      ST_LO_A: begin
        ctl_o.mul_op = twio_pkg::MUL_LO;
        ctl_o.dy_ld  = 1'b1;
        ctl_o.sin_ld = 1'b1;
      end
      ST_HI_A: begin
        ctl_o.mul_op = twio_pkg::MUL_HI;
        ctl_o.lo_ld  = 1'b1;
      end
      ST_LO_B: begin
        ctl_o.mul_op = twio_pkg::MUL_LO;
        ctl_o.d_y    = 1'b1;
        ctl_o.s_sin  = 1'b1;
        ctl_o.tm_ld  = 1'b1;
      end
      ST_HI_B: begin
        ctl_o.mul_op   = twio_pkg::MUL_HI;
        ctl_o.d_y      = 1'b1;
        ctl_o.s_sin    = 1'b1;
        ctl_o.t_neg    = 1'b1;
        ctl_o.lo_ld    = 1'b1;
        ctl_o.add_en   = 1'b1;
        ctl_o.add_init = 1'b1;
      end
      ST_LO_C: begin
        ctl_o.mul_op = twio_pkg::MUL_LO;
        ctl_o.s_sin  = 1'b1;
        ctl_o.tm_ld  = 1'b1;
      end
      ST_HI_C: begin
        ctl_o.mul_op = twio_pkg::MUL_HI;
        ctl_o.s_sin  = 1'b1;
        ctl_o.lo_ld  = 1'b1;
        ctl_o.add_en = 1'b1;
      end
      ST_LO_D: begin
        ctl_o.mul_op = twio_pkg::MUL_LO;
        ctl_o.d_y    = 1'b1;
        ctl_o.tm_ld  = 1'b1;
      end
      ST_HI_D: begin
        ctl_o.mul_op   = twio_pkg::MUL_HI;
        ctl_o.d_y      = 1'b1;
        ctl_o.lo_ld    = 1'b1;
        ctl_o.add_en   = 1'b1;
        ctl_o.add_y    = 1'b1;
        ctl_o.add_init = 1'b1;
      end
      ST_TERM_D: ctl_o.tm_ld = 1'b1;
      ST_ADD_D: begin
        ctl_o.add_en = 1'b1;
        ctl_o.add_y  = 1'b1;
      end
      ST_COMMIT: ctl_o.commit = slot_free;
      default: ctl_o.load = 1'b0;
    endcase
  end

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result committed over an untaken beat");

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> in_stall_o)
    else $error("input not stalled after a beat was taken");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl_o.commit))
    else $error("output valid without a commit");

  a_update_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.load && !in_cmd_i) |=> (state_q == ST_MUL_DX))
    else $error("update beat did not start the multiply schedule");

endmodule

### sim/tracking_wheel_imu_odometry_unit_test.sv
// tracking_wheel_imu_odometry_unit_test: self-checking bench for the odometry unit.
// A directed plan is followed by random phases, each checked against a local pose predictor.
// Depends on twio_pkg and tracking_wheel_imu_odometry_unit.
`timescale 1ns / 1ps

module tracking_wheel_imu_odometry_unit_test;

  localparam int unsigned IdxW = twio_pkg::CfgIdxW;
  localparam int unsigned SineBits = 10;
  localparam int unsigned SineSteps = 1 << SineBits;
  localparam bit [63:0] UnitQ31 = 64'd2147483648;
  localparam bit [63:0] SineHalfPi = 64'd3373259426;
  localparam bit [31:0] QuarterCycle = 32'h4000_0000;
  localparam longint I64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64Min = -I64Max - 1;
  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam int CycleLimit = 600000;
  localparam int Phases = 5;
  localparam int PhaseItems = 190;

  localparam bit CmdUpdate = 1'b0;
  localparam bit CmdSet = 1'b1;
  localparam logic [IdxW-1:0] RegSpare2 = IdxW'(2);
  localparam logic [IdxW-1:0] RegSpare3 = IdxW'(3);

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    bit        cmd;
    bit [31:0] x_count;
    bit [31:0] y_count;
    bit [31:0] imu_angle;
    bit [31:0] new_x;
    bit [31:0] new_y;
    bit [31:0] new_heading;
  } odo_item_t;

  typedef struct packed {
    bit [31:0] pos_x;
    bit [31:0] pos_y;
    bit [31:0] heading;
  } odo_pose_t;

  typedef struct packed {
    row_kind_e          kind;
    bit [IdxW-1:0]      reg_idx;
    bit [31:0]          reg_data;
    odo_item_t          item;
    bit                 typed;
    odo_pose_t          pose;
  } plan_row_t;

  localparam bit [31:0] Junk = 32'hA5C3_5A3C;
  localparam odo_item_t NoItem = '0;
  localparam odo_pose_t NoPose = '0;
  localparam int PlanRows = 24;

  localparam plan_row_t Plan [PlanRows] = '{
    // scales are zero after reset: no motion, heading follows the imu
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h0000_0064, 32'hFFFF_FFFB, 32'h1234_5678, Junk, ~Junk, Junk},
      1'b1, '{32'h0, 32'h0, 32'h1234_5678}},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdSet, Junk, ~Junk, Junk, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
      1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdSet, ~Junk, Junk, ~Junk, 32'h0, 32'h0, 32'h0},
      1'b1, '{32'h0, 32'h0, 32'h0}},
    // offset is now one: heading wraps to zero
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h7, 32'h7, 32'hFFFF_FFFF, Junk, Junk, ~Junk},
      1'b1, '{32'h0, 32'h0, 32'h0}},
    '{ROW_CFG, twio_pkg::RegXScale, 32'hFFFF_FFFF, NoItem, 1'b0, NoPose},
    '{ROW_CFG, twio_pkg::RegYScale, 32'hFFFF_FFFF, NoItem, 1'b0, NoPose},
    '{ROW_CFG, RegSpare2, 32'h1234_5678, NoItem, 1'b0, NoPose},
    '{ROW_CFG, RegSpare3, 32'hFFFF_FFFF, NoItem, 1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h0000_03EF, 32'h7, 32'h0, Junk, Junk, Junk}, 1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, Junk, Junk, Junk},
      1'b0, NoPose},
    // count wrap in both directions
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, Junk, Junk, Junk},
      1'b0, NoPose},
    // largest steps at each quadrant drive the sums into saturation
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h7FFF_FFFE, 32'hFFFF_FFFE, 32'h3FFF_FFFF, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'hBFFF_FFFF, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h7FFF_FFFE, 32'hFFFF_FFFF, 32'h0, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_CFG, twio_pkg::RegXScale, 32'h0001_2345, NoItem, 1'b0, NoPose},
    '{ROW_CFG, twio_pkg::RegYScale, 32'h8000_0000, NoItem, 1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdSet, Junk, Junk, Junk, 32'hFFFF_FFFF, 32'h0000_0001, 32'h4000_0000},
      1'b1, '{32'hFFFF_FFFF, 32'h0000_0001, 32'h4000_0000}},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h0000_012B, 32'hFFFF_FFD7, 32'h0010_0000, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h0000_012B, 32'hFFFF_FFD7, 32'h2000_0000, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h0000_022B, 32'hFFFF_FFFF, 32'hE000_0000, Junk, Junk, Junk},
      1'b0, NoPose},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdSet, ~Junk, ~Junk, ~Junk, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000},
      1'b1, '{32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000}},
    '{ROW_ITEM, twio_pkg::RegXScale, 32'h0,
      '{CmdUpdate, 32'h0000_032B, 32'h0000_0100, 32'h1234_5678, Junk, Junk, Junk},
      1'b0, NoPose}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic cmd = 1'b0;
  logic [31:0] x_count = '0;
  logic [31:0] y_count = '0;
  logic [31:0] imu_angle = '0;
  logic [31:0] new_x = '0;
  logic [31:0] new_y = '0;
  logic [31:0] new_heading = '0;
  logic out_stall = 1'b0;

  logic cfg_ready_o;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic [31:0] heading_o;

  bit calm = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;
  odo_pose_t poses_due [$];

  // predictor state
  bit [31:0] quarter_sine [0:SineSteps];
  longint odo_acc_x = 0;
  longint odo_acc_y = 0;
  bit [31:0] odo_heading = '0;
  bit [31:0] odo_heading_ofs = '0;
  bit [31:0] odo_prev_x = '0;
  bit [31:0] odo_prev_y = '0;
  bit [31:0] odo_scale_x = '0;
  bit [31:0] odo_scale_y = '0;

  tracking_wheel_imu_odometry_unit #(
    .SINE_TABLE_ADDR_BITS(SineBits)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd),
    .x_count_i     (x_count),
    .y_count_i     (y_count),
    .imu_angle_i   (imu_angle),
    .new_x_i       (new_x),
    .new_y_i       (new_y),
    .new_heading_i (new_heading),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .heading_o     (heading_o)
  );

  always #2 clk = ~clk;

  function automatic longint sine_q31(input bit [31:0] angle);
    bit [SineBits-1:0] idx;
    int unsigned k;
    longint v;
    idx = angle[29 -: SineBits];
    k = angle[30] ? SineSteps - idx : idx;
    v = longint'({32'd0, quarter_sine[k]});
    return angle[31] ? -v : v;
  endfunction

  // (d * s) >> 31 on magnitudes, sign restored afterwards
  function automatic longint rotate_term(input longint d, input longint s);
    bit neg;
    bit [63:0] ad;
    bit [63:0] sm;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] m;
    neg = (d < 0) != (s < 0);
    ad = d < 0 ? 64'(-d) : 64'(d);
    sm = s < 0 ? 64'(-s) : 64'(s);
    hi = (ad >> 32) * sm;
    lo = (ad & 64'h0000_0000_FFFF_FFFF) * sm;
    m = (hi << 1) + (lo >> 31);
    if (m > 64'(I64Max)) m = 64'(I64Max);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sum_clip64(input longint a, input longint b);
    if (b > 0 && a > I64Max - b) return I64Max;
    if (b < 0 && a < I64Min - b) return I64Min;
    return a + b;
  endfunction

  function automatic longint clip_q16_32(input longint v);
    if (v > AccMax) return AccMax;
    if (v < AccMin) return AccMin;
    return v;
  endfunction

  function automatic odo_pose_t advance_odometry(input odo_item_t it);
    odo_pose_t pose;
    bit [31:0] h;
    bit signed [31:0] step_x;
    bit signed [31:0] step_y;
    longint dx;
    longint dy;
    longint sn;
    longint cs;
    if (it.cmd == CmdSet) begin
      odo_acc_x = longint'(signed'(it.new_x)) * 65536;
      odo_acc_y = longint'(signed'(it.new_y)) * 65536;
      odo_heading_ofs = it.new_heading - odo_heading;
      odo_heading = it.new_heading;
    end else begin
      h = it.imu_angle + odo_heading_ofs;
      step_x = it.x_count - odo_prev_x;
      step_y = it.y_count - odo_prev_y;
      dx = longint'(step_x) * longint'({32'd0, odo_scale_x});
      dy = longint'(step_y) * longint'({32'd0, odo_scale_y});
      sn = sine_q31(h);
      cs = sine_q31(h + QuarterCycle);
      odo_acc_x = clip_q16_32(sum_clip64(odo_acc_x,
          sum_clip64(rotate_term(dx, cs), -rotate_term(dy, sn))));
      odo_acc_y = clip_q16_32(sum_clip64(odo_acc_y,
          sum_clip64(rotate_term(dx, sn), rotate_term(dy, cs))));
      odo_heading = h;
      odo_prev_x = it.x_count;
      odo_prev_y = it.y_count;
    end
    pose.pos_x = odo_acc_x[47:16];
    pose.pos_y = odo_acc_y[47:16];
    pose.heading = odo_heading;
    return pose;
  endfunction

  task automatic drive_item(input odo_item_t it, input bit typed, input odo_pose_t pose);
    odo_pose_t predicted;
    cfg_valid <= 1'b0;
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    x_count <= it.x_count;
    y_count <= it.y_count;
    imu_angle <= it.imu_angle;
    new_x <= it.new_x;
    new_y <= it.new_y;
    new_heading <= it.new_heading;
    do @(posedge clk); while (in_stall_o);
    predicted = advance_odometry(it);
    poses_due.push_back(typed ? pose : predicted);
  endtask

  // leaves cfg_valid high; the next item beat lowers it
  task automatic write_reg(input logic [IdxW-1:0] idx, input bit [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      twio_pkg::RegXScale: odo_scale_x = data;
      twio_pkg::RegYScale: odo_scale_y = data;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (poses_due.size() != 0 || in_stall_o) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 13);

  always @(posedge clk) begin : check_beat
    odo_pose_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (poses_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: x %h y %h heading %h", pos_x_o, pos_y_o, heading_o);
      end else begin
        want = poses_due.pop_front();
        if (pos_x_o !== want.pos_x || pos_y_o !== want.pos_y || heading_o !== want.heading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: expected x %h y %h heading %h, got x %h y %h heading %h",
                     want.pos_x, want.pos_y, want.heading, pos_x_o, pos_y_o, heading_o);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tracking_wheel_imu_odometry_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    bit [63:0] u;
    bit [63:0] u2;
    bit [63:0] r;
    odo_item_t it;
    bit [31:0] sx;
    bit [31:0] sy;
    for (int k = 0; k <= SineSteps; k++) begin
      u = (64'(k) * SineHalfPi) >> SineBits;
      u2 = (u * u) >> 31;
      r = UnitQ31;
      for (int n = 8; n >= 1; n--)
        r = UnitQ31 - ((u2 * r) >> 31) / (64'(2 * n) * 64'(2 * n + 1));
      quarter_sine[k] = 32'((u * r) >> 31);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int row = 0; row < PlanRows; row++) begin
      if (Plan[row].kind == ROW_CFG) begin
        if (row == 0 || Plan[row - 1].kind != ROW_CFG) settle();
        write_reg(Plan[row].reg_idx, Plan[row].reg_data);
      end else begin
        drive_item(Plan[row].item, Plan[row].typed, Plan[row].pose);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      settle();
      case (p)
        0: begin sx = 32'hFFFF_FFFF; sy = 32'hFFFF_FFFF; end
        1: begin sx = 32'h0; sy = $urandom; end
        4: begin sx = 32'h1; sy = 32'h8000_0000; end
        default: begin
          sx = $urandom >> $urandom_range(31);
          sy = $urandom >> $urandom_range(31);
        end
      endcase
      write_reg(twio_pkg::RegXScale, sx);
      write_reg(twio_pkg::RegYScale, sy);
      if ($urandom_range(1)) write_reg($urandom_range(1) ? RegSpare2 : RegSpare3, $urandom);
      calm = (p == 2);
      for (int i = 0; i < PhaseItems; i++) begin
        it.cmd = ($urandom_range(99) < 12) ? CmdSet : CmdUpdate;
        it.x_count = $urandom;
        it.y_count = $urandom;
        it.imu_angle = $urandom;
        it.new_x = $urandom;
        it.new_y = $urandom;
        it.new_heading = $urandom;
        // mostly small wheel motion so the sums stay in range for a while
        if (it.cmd == CmdUpdate && $urandom_range(99) < 85) begin
          it.x_count = odo_prev_x + 32'($urandom_range(4000)) - 32'd2000;
          it.y_count = odo_prev_y + 32'($urandom_range(4000)) - 32'd2000;
        end
        drive_item(it, 1'b0, NoPose);
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (poses_due.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatches == 0 && poses_due.size() == 0)
      $display("tracking_wheel_imu_odometry_unit_test OK");
    else
      $display("tracking_wheel_imu_odometry_unit_test NOT OK");
    $finish;
  end

endmodule
